[rtl/core/athash_pkg.sv]
// Shared types and constants for the allocation tracking hash table.
// Used by athash_ctrl, athash_dp and allocation_tracking_hash_table_unit.
package athash_pkg;

    localparam int unsigned TABLE_DEPTH_DEFAULT = 1024;

    localparam int unsigned ADDR_W   = 48;
    localparam int unsigned SIZE_W   = 32;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned SLOT_W   = 10;
    localparam int unsigned STATUS_W = 3;

    // Home slot remainder folds in one address digit in two steps:
    // multiply by the reciprocal of the depth, then subtract quotient times depth.
    localparam int unsigned MOD_DIGIT_W = 16;
    localparam int unsigned MOD_DIGITS  = ADDR_W / MOD_DIGIT_W;
    localparam int unsigned MOD_STEPS   = 2 * MOD_DIGITS;
    localparam int unsigned MOD_CNT_W   = $clog2(MOD_STEPS);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 3'd0,
        STS_DUP     = 3'd1,
        STS_FULL    = 3'd2,
        STS_UNKNOWN = 3'd3,
        STS_ZERO    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_PROBE,
        S_COMMIT,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic take;
        logic mod_step;
        logic probe_step;
        logic commit;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic addr_zero;
        logic mod_last;
        logic probe_done;
        logic probe_hit;
        logic out_busy;
    } sts_t;

endpackage

[rtl/core/athash_ctrl.sv]
// Sequencer for the allocation tracking hash table.
// Depends on athash_pkg; drives athash_dp through cmd_t and reads sts_t.
module athash_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  athash_pkg::sts_t  sts,
    output athash_pkg::cmd_t  cmd
);
    import athash_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (sts.addr_zero)
                begin
                    state_next = S_RESULT;
                end
                else if (sts.mod_last)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (sts.probe_done)
                begin
                    state_next = sts.probe_hit ? S_COMMIT : S_RESULT;
                end
            end
            S_COMMIT:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            S_MOD:
            begin
                cmd.mod_step = !sts.addr_zero;
            end
            S_PROBE:
            begin
                cmd.probe_step = 1'b1;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            S_RESULT:
            begin
                cmd.load_result = !sts.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/core/athash_dp.sv]
// Datapath for the allocation tracking hash table: modulo unit, slot table,
// probe compare, counters and output register. Depends on athash_pkg.
module athash_dp #(
    parameter int unsigned TABLE_DEPTH = athash_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  athash_pkg::cmd_t                   cmd,
    output athash_pkg::sts_t                   sts,
    input  logic                               op,
    input  logic [athash_pkg::ADDR_W-1:0]      address,
    input  logic [athash_pkg::SIZE_W-1:0]      size,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [athash_pkg::STATUS_W-1:0]    status,
    output logic [athash_pkg::SLOT_W-1:0]      slot,
    output logic [athash_pkg::SIZE_W-1:0]      freed_size,
    output logic [athash_pkg::CNT_W-1:0]       alloc_count,
    output logic [athash_pkg::CNT_W-1:0]       free_count,
    output logic [athash_pkg::ADDR_W-1:0]      reserved_bytes
);
    import athash_pkg::*;

    localparam int unsigned IDX_W = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CHK_W = $clog2(TABLE_DEPTH + 1);
    // One fold step divides {remainder so far, next digit}; the quotient is
    // exact for this dividend width with a reciprocal rounded up.
    localparam int unsigned X_W   = IDX_W + MOD_DIGIT_W;
    localparam int unsigned RSH   = X_W + IDX_W;
    localparam int unsigned RCP_W = X_W + 1;
    localparam int unsigned PRD_W = X_W + RCP_W;
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << RSH) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
    localparam logic [RCP_W-1:0]     RCP      = RCP_W'(RCP_FULL);
    localparam logic [X_W-1:0]       DEPTH_X  = X_W'(TABLE_DEPTH);
    localparam logic [CHK_W-1:0]     DEPTH_C  = CHK_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(MOD_STEPS - 1);

    logic [ADDR_W-1:0] addr_mem [TABLE_DEPTH];
    logic [SIZE_W-1:0] size_mem [TABLE_DEPTH];

    logic              op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] mod_shift_reg;
    logic [IDX_W-1:0]  rem_reg;
    logic [IDX_W-1:0]  rem_next;
    logic [X_W-1:0]    mod_x_reg;
    logic [MOD_DIGIT_W-1:0] mod_q_reg;
    logic [MOD_CNT_W-1:0] mod_cnt_reg;
    logic [IDX_W-1:0]  clr_idx_reg;
    logic [IDX_W-1:0]  rd_pos_reg;
    logic [IDX_W-1:0]  chk_pos_reg;
    logic              rd_valid_reg;
    logic [CHK_W-1:0]  chk_cnt_reg;
    logic [ADDR_W-1:0] addr_rd_reg;
    logic [SIZE_W-1:0] size_rd_reg;
    logic [IDX_W-1:0]  hit_pos_reg;
    logic [SIZE_W-1:0] freed_reg;
    status_t           status_reg;
    status_t           probe_status;
    logic [CNT_W-1:0]  alloc_cnt_reg;
    logic [CNT_W-1:0]  free_cnt_reg;
    logic [ADDR_W-1:0] bytes_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [SIZE_W-1:0]   out_freed_reg;
    logic [CNT_W-1:0]    out_alloc_reg;
    logic [CNT_W-1:0]    out_free_reg;
    logic [ADDR_W-1:0]   out_bytes_reg;

    logic cur_empty;
    logic cur_match;
    logic last_chk;
    logic probe_done;
    logic probe_hit;
    logic mod_last;
    logic result_ok;
    logic              mem_we;
    logic [IDX_W-1:0]  wr_idx;
    logic [ADDR_W-1:0] wr_addr;
    logic [IDX_W-1:0]  rd_pos_inc;
    logic [IDX_W-1:0]  clr_idx_inc;
    logic [X_W-1:0]    mod_x;
    logic [PRD_W-1:0]  mod_prod;
    logic [X_W-1:0]    mod_qd;
    logic [X_W-1:0]    mod_diff;

    // Even step: quotient of {remainder, next digit} by reciprocal multiply.
    // Odd step: remainder = dividend - quotient * depth.
    assign mod_x    = {rem_reg, mod_shift_reg[ADDR_W-1 -: MOD_DIGIT_W]};
    assign mod_prod = PRD_W'(mod_x) * PRD_W'(RCP);
    assign mod_qd   = X_W'(mod_q_reg) * DEPTH_X;
    assign mod_diff = mod_x_reg - mod_qd;
    assign rem_next = mod_diff[IDX_W-1:0];

    assign mod_last    = (mod_cnt_reg == MOD_LAST);
    assign rd_pos_inc  = (rd_pos_reg == LAST_IDX) ? '0 : rd_pos_reg + IDX_W'(1);
    assign clr_idx_inc = (clr_idx_reg == LAST_IDX) ? '0 : clr_idx_reg + IDX_W'(1);

    // Compare the slot whose read came back last cycle.
    assign cur_empty = (addr_rd_reg == '0);
    assign cur_match = (addr_rd_reg == addr_reg);
    assign last_chk  = ((chk_cnt_reg + CHK_W'(1)) == DEPTH_C);

    always_comb
    begin
        if (op_reg == OP_ALLOC)
        begin
            probe_done = rd_valid_reg && (cur_empty || cur_match || last_chk);
            probe_hit  = rd_valid_reg && cur_empty;
            if (cur_empty)
            begin
                probe_status = STS_OK;
            end
            else if (cur_match)
            begin
                probe_status = STS_DUP;
            end
            else
            begin
                probe_status = STS_FULL;
            end
        end
        else
        begin
            probe_done   = rd_valid_reg && (cur_match || last_chk);
            probe_hit    = rd_valid_reg && cur_match;
            probe_status = cur_match ? STS_OK : STS_UNKNOWN;
        end
    end

    assign sts.clr_last   = (clr_idx_reg == LAST_IDX);
    assign sts.addr_zero  = (addr_reg == '0);
    assign sts.mod_last   = mod_last;
    assign sts.probe_done = probe_done;
    assign sts.probe_hit  = probe_hit;
    assign sts.out_busy   = out_valid_reg && !out_ready;

    // Single write port: clearing sweep or commit.
    assign mem_we  = cmd.clr_step || cmd.commit;
    assign wr_idx  = cmd.clr_step ? clr_idx_reg : hit_pos_reg;
    assign wr_addr = (cmd.commit && op_reg == OP_ALLOC) ? addr_reg : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            addr_mem[wr_idx] <= wr_addr;
        end
        if (cmd.commit && op_reg == OP_ALLOC)
        begin
            size_mem[hit_pos_reg] <= size_reg;
        end
        if (cmd.probe_step)
        begin
            addr_rd_reg <= addr_mem[rd_pos_reg];
            size_rd_reg <= size_mem[rd_pos_reg];
        end
    end

    // Payload and datapath working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg        <= op;
            addr_reg      <= address;
            size_reg      <= size;
            mod_shift_reg <= address;
            rem_reg       <= '0;
            status_reg    <= (address == '0) ? STS_ZERO : STS_OK;
        end
        if (cmd.mod_step)
        begin
            if (!mod_cnt_reg[0])
            begin
                mod_x_reg     <= mod_x;
                mod_q_reg     <= mod_prod[RSH +: MOD_DIGIT_W];
                mod_shift_reg <= mod_shift_reg << MOD_DIGIT_W;
            end
            else
            begin
                rem_reg <= rem_next;
            end
            if (mod_last)
            begin
                rd_pos_reg <= rem_next;
            end
        end
        if (cmd.probe_step)
        begin
            chk_pos_reg <= rd_pos_reg;
            rd_pos_reg  <= rd_pos_inc;
            if (probe_done)
            begin
                status_reg  <= probe_status;
                hit_pos_reg <= chk_pos_reg;
                freed_reg   <= size_rd_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg   <= '0;
            mod_cnt_reg   <= '0;
            rd_valid_reg  <= 1'b0;
            chk_cnt_reg   <= '0;
            alloc_cnt_reg <= '0;
            free_cnt_reg  <= '0;
            bytes_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_idx_reg <= clr_idx_inc;
            end
            if (cmd.take)
            begin
                mod_cnt_reg <= '0;
            end
            if (cmd.mod_step)
            begin
                mod_cnt_reg <= mod_cnt_reg + MOD_CNT_W'(1);
                if (mod_last)
                begin
                    rd_valid_reg <= 1'b0;
                    chk_cnt_reg  <= '0;
                end
            end
            if (cmd.probe_step)
            begin
                rd_valid_reg <= 1'b1;
                if (rd_valid_reg && !probe_done)
                begin
                    chk_cnt_reg <= chk_cnt_reg + CHK_W'(1);
                end
            end
            if (cmd.commit)
            begin
                if (op_reg == OP_ALLOC)
                begin
                    alloc_cnt_reg <= alloc_cnt_reg + CNT_W'(1);
                    bytes_reg     <= bytes_reg + ADDR_W'(size_reg);
                end
                else
                begin
                    free_cnt_reg <= free_cnt_reg + CNT_W'(1);
                    bytes_reg    <= bytes_reg - ADDR_W'(freed_reg);
                end
            end
            if (cmd.load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_ok = (status_reg == STS_OK);

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_status_reg <= status_reg;
            out_slot_reg   <= result_ok ? SLOT_W'(hit_pos_reg) : '0;
            out_freed_reg  <= (result_ok && op_reg == OP_FREE) ? freed_reg : '0;
            out_alloc_reg  <= alloc_cnt_reg;
            out_free_reg   <= free_cnt_reg;
            out_bytes_reg  <= bytes_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign slot           = out_slot_reg;
    assign freed_size     = out_freed_reg;
    assign alloc_count    = out_alloc_reg;
    assign free_count     = out_free_reg;
    assign reserved_bytes = out_bytes_reg;

endmodule

[rtl/core/allocation_tracking_hash_table_unit.sv]
// Top level of the allocation tracking hash table.
// Depends on athash_pkg, athash_ctrl and athash_dp.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    op, address, size
//   output    out_valid / out_ready  status, slot, freed_size, alloc_count,
//                                    free_count, reserved_bytes
//
// One request at a time: accept, then the home-slot modulo (one 16-bit
// address digit in two steps: reciprocal multiply, then subtract), then the
// probe of slots through the single table read port, then a commit when a
// slot is written or cleared, then a load of the output register. A zero
// address skips the modulo and the probe.
// After reset the table is swept to empty, one slot a cycle; in_ready stays
// low meanwhile. A result waiting in the output register does not block
// accepting the next request, only its completion.
module allocation_tracking_hash_table_unit #(
    parameter int unsigned TABLE_DEPTH = athash_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               op,
    input  logic [athash_pkg::ADDR_W-1:0]      address,
    input  logic [athash_pkg::SIZE_W-1:0]      size,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [athash_pkg::STATUS_W-1:0]    status,
    output logic [athash_pkg::SLOT_W-1:0]      slot,
    output logic [athash_pkg::SIZE_W-1:0]      freed_size,
    output logic [athash_pkg::CNT_W-1:0]       alloc_count,
    output logic [athash_pkg::CNT_W-1:0]       free_count,
    output logic [athash_pkg::ADDR_W-1:0]      reserved_bytes
);
    import athash_pkg::*;

    cmd_t cmd;
    sts_t sts;

    athash_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    athash_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .op             (op),
        .address        (address),
        .size           (size),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .slot           (slot),
        .freed_size     (freed_size),
        .alloc_count    (alloc_count),
        .free_count     (free_count),
        .reserved_bytes (reserved_bytes)
    );

    // Only one request in flight.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in flight");

    // Error results carry no slot and no freed size.
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STS_OK) |-> (slot == '0) && (freed_size == '0))
        else $error("error result with nonzero slot or freed size");

    // Hold a stalled result unchanged until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({status, slot, freed_size, alloc_count, free_count, reserved_bytes}))
        else $error("stalled result dropped or changed");

endmodule

[test/allocation_tracking_hash_table_unit_tb.sv]
// Testbench for allocation_tracking_hash_table_unit: directed table, random traffic, then fill and drain.
// Keeps its own copy of the probing table to predict every result.
// Depends on athash_pkg and the unit's RTL.
module allocation_tracking_hash_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import athash_pkg::*;

    // Home slot below is taken from the low 10 address bits, so depth stays 1024.
    localparam int unsigned DEPTH        = 1024;
    localparam int unsigned RANDOM_ITEMS = 1300;
    localparam int unsigned TAIL_CYCLES  = 64;

    typedef struct packed {
        logic                op;
        logic [ADDR_W-1:0]   addr;
        logic [SIZE_W-1:0]   size;
        logic                typed;
        status_t             st;
        logic [SLOT_W-1:0]   slot_idx;
        logic [SIZE_W-1:0]   freed;
    } stim_row_t;

    typedef struct packed {
        status_t             st;
        logic [SLOT_W-1:0]   slot_idx;
        logic [SIZE_W-1:0]   freed;
        logic [CNT_W-1:0]    allocs;
        logic [CNT_W-1:0]    frees;
        logic [ADDR_W-1:0]   bytes;
    } outcome_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic                 op        = OP_ALLOC;
    logic [ADDR_W-1:0]    address   = '0;
    logic [SIZE_W-1:0]    size      = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    slot;
    logic [SIZE_W-1:0]    freed_size;
    logic [CNT_W-1:0]     alloc_count;
    logic [CNT_W-1:0]     free_count;
    logic [ADDR_W-1:0]    reserved_bytes;

    // Predictor state
    logic [ADDR_W-1:0]    held_addr [DEPTH];
    logic [SIZE_W-1:0]    held_size [DEPTH];
    logic [CNT_W-1:0]     allocs_total = '0;
    logic [CNT_W-1:0]     frees_total  = '0;
    logic [ADDR_W-1:0]    bytes_held   = '0;
    int unsigned          live_count   = 0;

    outcome_t             outcomes_due [$];
    int                   fault_count  = 0;
    int unsigned          burst_left   = 0;

    stim_row_t directed_rows [25] = '{
        '{OP_FREE,  48'h0,            32'h0,        1'b1, STS_ZERO,    10'd0,    32'h0},
        '{OP_ALLOC, 48'h0,            32'hFFFFFFFF, 1'b1, STS_ZERO,    10'd0,    32'h0},
        '{OP_FREE,  48'h5,            32'h0,        1'b1, STS_UNKNOWN, 10'd0,    32'h0},
        '{OP_ALLOC, 48'h5,            32'h10,       1'b1, STS_OK,      10'd5,    32'h0},
        '{OP_ALLOC, 48'h5,            32'h1,        1'b1, STS_DUP,     10'd0,    32'h0},
        '{OP_ALLOC, 48'h405,          32'h20,       1'b1, STS_OK,      10'd6,    32'h0},
        '{OP_FREE,  48'h5,            32'h0,        1'b1, STS_OK,      10'd5,    32'h10},
        // copy of 0x405 lands in front of the first one: duplicate hidden by a hole
        '{OP_ALLOC, 48'h405,          32'h7,        1'b1, STS_OK,      10'd5,    32'h0},
        '{OP_FREE,  48'h405,          32'h0,        1'b1, STS_OK,      10'd5,    32'h7},
        '{OP_FREE,  48'h405,          32'h0,        1'b1, STS_OK,      10'd6,    32'h20},
        '{OP_FREE,  48'h405,          32'h0,        1'b1, STS_UNKNOWN, 10'd0,    32'h0},
        '{OP_ALLOC, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 1'b1, STS_OK,      10'd1023, 32'h0},
        '{OP_ALLOC, 48'hFFFFFFFFFBFF, 32'hFFFFFFFF, 1'b1, STS_OK,      10'd0,    32'h0},
        '{OP_ALLOC, 48'h000000000BFF, 32'h80000000, 1'b1, STS_OK,      10'd1,    32'h0},
        '{OP_ALLOC, 48'h800000000000, 32'h0,        1'b1, STS_OK,      10'd2,    32'h0},
        '{OP_FREE,  48'hFFFFFFFFFBFF, 32'h0,        1'b1, STS_OK,      10'd0,    32'hFFFFFFFF},
        '{OP_FREE,  48'h800000000000, 32'h0,        1'b1, STS_OK,      10'd2,    32'h0},
        '{OP_ALLOC, 48'h000000000001, 32'h1234,     1'b0, STS_OK,      10'd0,    32'h0},
        '{OP_FREE,  48'hFFFFFFFFFFFF, 32'h0,        1'b1, STS_OK,      10'd1023, 32'hFFFFFFFF},
        '{OP_FREE,  48'h000000000BFF, 32'h0,        1'b1, STS_OK,      10'd1,    32'h80000000},
        '{OP_FREE,  48'h000000000001, 32'hFFFFFFFF, 1'b0, STS_OK,      10'd0,    32'h0},
        '{OP_ALLOC, 48'h555555555555, 32'hAAAAAAAA, 1'b0, STS_OK,      10'd0,    32'h0},
        '{OP_ALLOC, 48'hAAAAAAAAAAAA, 32'h55555555, 1'b0, STS_OK,      10'd0,    32'h0},
        '{OP_FREE,  48'h555555555555, 32'h0,        1'b0, STS_OK,      10'd0,    32'h0},
        '{OP_FREE,  48'hAAAAAAAAAAAA, 32'h0,        1'b0, STS_OK,      10'd0,    32'h0}
    };

    allocation_tracking_hash_table_unit #(
        .TABLE_DEPTH    (DEPTH)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .address        (address),
        .size           (size),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .slot           (slot),
        .freed_size     (freed_size),
        .alloc_count    (alloc_count),
        .free_count     (free_count),
        .reserved_bytes (reserved_bytes)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #150_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Apply one request to the tracked table and return what the unit must answer.
    function automatic outcome_t track_request(logic is_free, logic [ADDR_W-1:0] a,
                                               logic [SIZE_W-1:0] s);
        outcome_t    r;
        int unsigned pos;
        int unsigned n;
        bit          found_empty;
        bit          hit;

        r.st          = STS_OK;
        r.slot_idx    = '0;
        r.freed       = '0;
        found_empty   = 1'b0;
        hit           = 1'b0;
        pos           = 32'(a % DEPTH);
        if (a == '0)
        begin
            r.st = STS_ZERO;
        end
        else if (is_free == OP_ALLOC)
        begin
            // stop at the first hole; a copy beyond it goes unseen
            for (n = 0; n < DEPTH && !found_empty && !hit; n++)
            begin
                if (held_addr[pos] == '0)
                    found_empty = 1'b1;
                else if (held_addr[pos] == a)
                    hit = 1'b1;
                else
                    pos = (pos + 1) % DEPTH;
            end
            if (hit)
                r.st = STS_DUP;
            else if (!found_empty)
                r.st = STS_FULL;
            else
            begin
                held_addr[pos] = a;
                held_size[pos] = s;
                r.slot_idx     = SLOT_W'(pos);
                allocs_total   = allocs_total + 1'b1;
                bytes_held     = bytes_held + ADDR_W'(s);
                live_count++;
            end
        end
        else
        begin
            for (n = 0; n < DEPTH && !hit; n++)
            begin
                if (held_addr[pos] == a)
                    hit = 1'b1;
                else
                    pos = (pos + 1) % DEPTH;
            end
            if (!hit)
                r.st = STS_UNKNOWN;
            else
            begin
                r.freed        = held_size[pos];
                r.slot_idx     = SLOT_W'(pos);
                held_addr[pos] = '0;
                frees_total    = frees_total + 1'b1;
                bytes_held     = bytes_held - ADDR_W'(held_size[pos]);
                live_count--;
            end
        end
        r.allocs = allocs_total;
        r.frees  = frees_total;
        r.bytes  = bytes_held;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_live();
        int unsigned start;
        int unsigned k;

        start = $urandom_range(DEPTH - 1);
        for (k = 0; k < DEPTH; k++)
        begin
            if (held_addr[(start + k) % DEPTH] != '0)
                return held_addr[(start + k) % DEPTH];
        end
        return '0;
    endfunction

    // Clustered homes build long probe chains, some across the wrap.
    function automatic logic [ADDR_W-1:0] fresh_address(bit clustered);
        logic [ADDR_W-1:0] a;
        int unsigned       pick;

        a[47:16] = $urandom();
        a[15:0]  = 16'($urandom());
        pick     = $urandom_range(9);
        if (clustered && pick < 3)
            a[9:0] = 10'((DEPTH - 8 + $urandom_range(15)) % DEPTH);
        else if (clustered && pick < 5)
            a[9:0] = 10'(300 + $urandom_range(7));
        return a;
    endfunction

    function automatic logic [SIZE_W-1:0] random_size();
        int unsigned pick;

        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return $urandom();
    endfunction

    function automatic stim_row_t make_row(logic o, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] s);
        stim_row_t row;

        row.op       = o;
        row.addr     = a;
        row.size     = s;
        row.typed    = 1'b0;
        row.st       = STS_OK;
        row.slot_idx = '0;
        row.freed    = '0;
        return row;
    endfunction

    // Present one request, hold it until taken, then record its expected result.
    task automatic issue(input stim_row_t row);
        outcome_t want;

        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
            if ($urandom_range(5) == 0)
                burst_left = $urandom_range(100, 300);
            else
                burst_left = $urandom_range(1, 20);
        end
        in_valid <= 1'b1;
        op       <= row.op;
        address  <= row.addr;
        size     <= row.size;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        want = track_request(row.op, row.addr, row.size);
        if (row.typed)
        begin
            want.st       = row.st;
            want.slot_idx = row.slot_idx;
            want.freed    = row.freed;
        end
        outcomes_due.push_back(want);
        burst_left--;
    endtask

    task automatic compare_field(input string name, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, got_v);
            fault_count++;
        end
    endtask

    // Receiver: switch between stall patterns, holding each for a random stretch.
    initial
    begin : sink_pattern
        int unsigned mode  = 0;
        int unsigned hold  = 0;
        int unsigned phase = 0;

        forever
        begin
            @(posedge clk);
            if (hold == 0)
            begin
                mode = $urandom_range(3);
                hold = $urandom_range(40, 300);
            end
            hold--;
            phase++;
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(9) < 7);
                2: out_ready <= ((phase % 5) != 0);
                default: out_ready <= ($urandom_range(15) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : result_check
        outcome_t want;

        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (outcomes_due.size() == 0)
            begin
                $display("%0t: unexpected result, status %0d slot %0d", $time, status, slot);
                fault_count++;
            end
            else
            begin
                want = outcomes_due.pop_front();
                compare_field("status", 64'(want.st), 64'(status));
                compare_field("slot", 64'(want.slot_idx), 64'(slot));
                compare_field("freed_size", 64'(want.freed), 64'(freed_size));
                compare_field("alloc_count", 64'(want.allocs), 64'(alloc_count));
                compare_field("free_count", 64'(want.frees), 64'(free_count));
                compare_field("reserved_bytes", 64'(want.bytes), 64'(reserved_bytes));
            end
        end
    end

    initial
    begin : stimulus
        int          i;
        int unsigned r;
        stim_row_t   row;
        logic [ADDR_W-1:0] a;
        logic [SIZE_W-1:0] s;

        for (i = 0; i < DEPTH; i++)
        begin
            held_addr[i] = '0;
            held_size[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
            issue(directed_rows[k]);

        // Mixed traffic; allocation odds fall as the table fills, holding ~300 live.
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            r = $urandom_range(99);
            a = fresh_address(1'b1);
            s = random_size();
            if (r < 3)
                row = make_row(($urandom_range(1) == 1) ? OP_FREE : OP_ALLOC, '0, s);
            else if (r < 5)
                row = make_row(OP_FREE, a, s);
            else if (r < 10 && live_count != 0)
                row = make_row(OP_ALLOC, pick_live(), s);
            else if (live_count == 0 || $urandom_range(599) >= live_count)
                row = make_row(OP_ALLOC, a, s);
            else
                row = make_row(OP_FREE, pick_live(), s);
            issue(row);
        end

        // Fill the table, hit it while full, then drain part of it and refill.
        while (live_count < DEPTH)
            issue(make_row(OP_ALLOC, fresh_address(1'b0), random_size()));
        for (i = 0; i < 6; i++)
            issue(make_row(OP_ALLOC, fresh_address(1'b1), random_size()));
        issue(make_row(OP_ALLOC, pick_live(), random_size()));
        issue(make_row(OP_ALLOC, pick_live(), random_size()));
        issue(make_row(OP_ALLOC, '0, random_size()));
        issue(make_row(OP_FREE, fresh_address(1'b0), random_size()));
        for (i = 0; i < 40; i++)
            issue(make_row(OP_FREE, pick_live(), random_size()));
        for (i = 0; i < 20; i++)
            issue(make_row(OP_ALLOC, fresh_address(1'b1), random_size()));
        in_valid <= 1'b0;

        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/athash_pkg.sv
rtl/core/athash_ctrl.sv
rtl/core/athash_dp.sv
rtl/core/allocation_tracking_hash_table_unit.sv
test/allocation_tracking_hash_table_unit_tb.sv
